// ===== hw/rtl/sidec_pkg.sv =====
// Package for the signed integer to decimal ASCII converter.
// Holds widths, character codes, the sequencer state type and a digit-count helper.
// No dependencies.
`timescale 1ns / 1ps

package sidec_pkg;

    // Default width of the input integer
    localparam int VALUE_BITS_DEF = 32;

    // Result character width and codes
    localparam int          CHAR_W      = 6;
    localparam logic [5:0]  ASCII_ZERO  = 6'd48;
    localparam logic [5:0]  ASCII_MINUS = 6'd45;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_SIGN,
        ST_DIGIT
    } sidec_state_t;

    // Upper bound on decimal digits of a magnitude of up to 'bits' bits
    // (floor(bits * log10(2)) + 1)
    function automatic int num_digits(input int bits);
        return (bits * 30103) / 100000 + 1;
    endfunction

endpackage

// ===== hw/rtl/signed_int_to_decimal_ascii.sv =====
// Top level: converts a two's complement integer to its decimal ASCII text.
// Shift-and-add-3 (double dabble) converter under a small sequencer.
// Depends on sidec_pkg.
`timescale 1ns / 1ps

// Channel  | Dir | Handshake          | Payload
// ---------+-----+--------------------+---------------------------------------
// s_       | in  | s_tvalid/s_tready  | s_tdata: value (VALUE_BITS, signed)
// m_       | out | m_tvalid/m_tready  | m_tdata: character (6 bits), m_tlast: last
//
// One item: an accept, then the conversion, one bit per cycle through the shared
// add-3/shift unit, then the characters out one at a time: the digits, plus one
// for a minus sign.
// s_tready is high only while the sequencer is idle.
// A stalled m_tready holds the output register and pauses character emission.
// aresetn is synchronous, active low, and clears the sequencer and m_tvalid.

module signed_int_to_decimal_ascii #(
    parameter int VALUE_BITS = sidec_pkg::VALUE_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // s_tdata: [VALUE_BITS-1:0] value, rest zero fill to whole bytes
    input  logic [((VALUE_BITS+7)/8)*8-1:0]     s_tdata,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // m_tdata: [5:0] character, [7:6] zero
    output logic [7:0]                          m_tdata,
    output logic                                m_tlast,
    output logic                                m_tvalid,
    input  logic                                m_tready
);
    import sidec_pkg::*;

    localparam int DIGITS = num_digits(VALUE_BITS);
    localparam int IDX_W  = $clog2(DIGITS + 1);
    localparam int DIG_IW = (DIGITS > 1) ? $clog2(DIGITS) : 1;
    localparam int CNT_W  = $clog2(VALUE_BITS);

    // Sequencer and datapath registers
    sidec_state_t                   state_reg, state_next;
    logic [VALUE_BITS-1:0]          mag_reg, mag_next;
    logic [DIGITS-1:0][3:0]         bcd_reg, bcd_next;
    logic [IDX_W-1:0]               idx_reg, idx_next;
    logic [CNT_W-1:0]               cnt_reg, cnt_next;
    logic                           neg_reg, neg_next;

    // Output register
    logic                           ovld_reg, ovld_next;
    logic [CHAR_W-1:0]              ochar_reg, ochar_next;
    logic                           olast_reg, olast_next;

    // Combinational helpers
    logic [VALUE_BITS-1:0]          in_value;
    logic [DIGITS-1:0][3:0]         bcd_adj;
    logic [DIGITS*4-1:0]            bcd_shift;
    logic [IDX_W-1:0]               rd_idx;
    logic [3:0]                     shift_digit;
    logic [3:0]                     emit_digit;
    logic [IDX_W-1:0]               ndig;
    logic                           out_free;

    assign in_value = s_tdata[VALUE_BITS-1:0];
    assign out_free = !ovld_reg || m_tready;

    // Shared unit: add 3 to each digit of 5 or more, then shift in the next bit
    // (the top digit never reaches 8, so its high bit drops out unused)
    always_comb begin
        for (int d = 0; d < DIGITS; d++) begin
            bcd_adj[d] = (bcd_reg[d] >= 4'd5) ? bcd_reg[d] + 4'd3 : bcd_reg[d];
        end
        bcd_shift = {bcd_adj[DIGITS-1][2:0], bcd_adj[DIGITS-2:0],
                     mag_reg[VALUE_BITS-1]};
    end

    // Single digit read port: next-value digit while converting, stored digit on emit
    assign rd_idx = (state_reg == ST_CONV) ? idx_reg : idx_reg - IDX_W'(1);

    always_comb begin
        shift_digit = 4'd0;
        emit_digit  = 4'd0;
        if (rd_idx < IDX_W'(DIGITS)) begin
            shift_digit = bcd_shift[4*rd_idx[DIG_IW-1:0] +: 4];
            emit_digit  = bcd_reg[rd_idx[DIG_IW-1:0]];
        end
    end

    // Significant digit count grows by at most one per shift
    assign ndig = (idx_reg < IDX_W'(DIGITS) && shift_digit != 4'd0)
                  ? idx_reg + IDX_W'(1) : idx_reg;

    // State register and datapath
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ovld_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            ovld_reg  <= ovld_next;
        end
        mag_reg   <= mag_next;
        bcd_reg   <= bcd_next;
        idx_reg   <= idx_next;
        cnt_reg   <= cnt_next;
        neg_reg   <= neg_next;
        ochar_reg <= ochar_next;
        olast_reg <= olast_next;
    end

    // Next state and outputs
    always_comb begin
        state_next = state_reg;
        mag_next   = mag_reg;
        bcd_next   = bcd_reg;
        idx_next   = idx_reg;
        cnt_next   = cnt_reg;
        neg_next   = neg_reg;
        ovld_next  = ovld_reg && !m_tready;
        ochar_next = ochar_reg;
        olast_next = olast_reg;
        s_tready   = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    neg_next   = in_value[VALUE_BITS-1];
                    mag_next   = in_value[VALUE_BITS-1] ? (~in_value + 1'b1) : in_value;
                    bcd_next   = '0;
                    idx_next   = '0;
                    cnt_next   = CNT_W'(VALUE_BITS - 1);
                    state_next = ST_CONV;
                end
            end
            ST_CONV: begin
                bcd_next = bcd_shift;
                mag_next = {mag_reg[VALUE_BITS-2:0], 1'b0};
                idx_next = ndig;
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0) begin
                    // Zero still prints one digit
                    if (ndig == '0) begin
                        idx_next = IDX_W'(1);
                    end
                    state_next = neg_reg ? ST_SIGN : ST_DIGIT;
                end
            end
            ST_SIGN: begin
                if (out_free) begin
                    ovld_next  = 1'b1;
                    ochar_next = ASCII_MINUS;
                    olast_next = 1'b0;
                    state_next = ST_DIGIT;
                end
            end
            ST_DIGIT: begin
                if (out_free) begin
                    ovld_next  = 1'b1;
                    ochar_next = ASCII_ZERO + {2'b00, emit_digit};
                    olast_next = (idx_reg == IDX_W'(1));
                    idx_next   = idx_reg - IDX_W'(1);
                    if (idx_reg == IDX_W'(1)) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = ovld_reg;
    assign m_tdata  = {2'b00, ochar_reg};
    assign m_tlast  = olast_reg;

endmodule

// ===== hw/rtl/sidec_checker.sv =====
// Port-level checker for signed_int_to_decimal_ascii, attached by bind.
// Watches the handshakes and the character stream; no package needed.
`timescale 1ns / 1ps

module sidec_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast,
    input logic       m_tvalid,
    input logic       m_tready
);

    // A stalled result holds its payload
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed");

    // An accepted item closes the input right after the accept
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input ready right after accept");

    // Only a minus sign or a digit leaves the block
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata == 8'd45) || (m_tdata >= 8'd48 && m_tdata <= 8'd57))
        else $error("bad character");

    // A minus sign is never the final character
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata == 8'd45 |-> !m_tlast)
        else $error("minus sign marked last");

endmodule

bind signed_int_to_decimal_ascii sidec_checker u_sidec_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);

// ===== verif/testbench.sv =====
// Testbench for signed_int_to_decimal_ascii: a table of directed values, then random
// values with bursty input, receiver stalls and a long output hold-off, all checked per
// character against the table text or a local decimal predictor. Depends on sidec_pkg.
`timescale 1ns / 1ps

module testbench;

    localparam int VALUE_BITS  = sidec_pkg::VALUE_BITS_DEF;
    localparam int TDATA_W     = ((VALUE_BITS + 7) / 8) * 8;
    localparam int RAND_ITEMS  = 340;
    localparam int HOLD_AT     = 120;   // random item at which the long hold-off starts
    localparam int PAUSE_AT    = 240;   // random item before which the source drains
    localparam int HOLD_CYCLES = 300;
    localparam int QUIET_LIMIT = 2000;  // cycles with no item moving on either side
    localparam int DRAIN       = 60;

    // One expected output character
    typedef struct {
        logic [5:0] code;
        logic       last;
    } char_exp_t;

    // Directed row: empty text means the predictor supplies the characters
    typedef struct {
        logic [VALUE_BITS-1:0] value;
        string                 text;
    } vector_row_t;

    // Receiver stall patterns
    typedef enum int {
        RX_OPEN,
        RX_COIN,
        RX_ONE_IN_FOUR,
        RX_MOSTLY
    } rx_pattern_t;

    logic               aclk     = 1'b0;
    logic               aresetn  = 1'b0;
    logic [TDATA_W-1:0] s_tdata  = '0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [7:0]         m_tdata;
    logic               m_tlast;
    logic               m_tvalid;
    logic               m_tready = 1'b0;

    char_exp_t pending_chars[$];
    int        mismatches    = 0;
    int        quiet_cycles  = 0;
    int        burst_left    = 0;
    bit        hold_request  = 1'b0;

    vector_row_t vectors [20] = '{
        '{32'd0,                 "0"},
        '{32'd1,                 "1"},
        '{32'hFFFF_FFFF,         "-1"},
        '{32'd9,                 "9"},
        '{32'd10,                "10"},
        '{-32'sd10,              "-10"},
        '{32'h7FFF_FFFF,         "2147483647"},
        '{32'h8000_0000,         "-2147483648"},
        '{32'h8000_0001,         "-2147483647"},
        '{32'd1000000000,        "1000000000"},
        '{-32'sd1000000000,      "-1000000000"},
        '{32'd999999999,         ""},
        '{32'd99,                ""},
        '{32'd100,               ""},
        '{32'h5555_5555,         ""},
        '{32'hAAAA_AAAA,         ""},
        '{32'd12345,             ""},
        '{-32'sd987654321,       ""},
        '{32'h0000_FFFF,         ""},
        '{32'hFFFF_0000,         ""}
    };

    signed_int_to_decimal_ascii #(
        .VALUE_BITS(VALUE_BITS)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tdata (s_tdata),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready)
    );

    always #1 aclk = ~aclk;

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        mismatches++;
    endtask

    // Decimal text of one value: optional minus, then digits most significant first
    function automatic void predict_decimal(input logic [VALUE_BITS-1:0] value);
        logic [VALUE_BITS-1:0] mag;
        logic [3:0]            digit [0:19];
        int                    ndig;
        ndig = 0;
        // most negative value wraps to itself, which is the right magnitude unsigned
        mag = value[VALUE_BITS-1] ? (~value + 1'b1) : value;
        do begin
            digit[ndig] = 4'(mag % 10);
            mag = mag / 10;
            ndig++;
        end while (mag != 0);
        if (value[VALUE_BITS-1])
            pending_chars.push_back('{sidec_pkg::ASCII_MINUS, 1'b0});
        for (int k = ndig - 1; k >= 0; k--)
            pending_chars.push_back('{sidec_pkg::ASCII_ZERO + 6'(digit[k]), k == 0});
    endfunction

    function automatic void push_text(input string text);
        for (int i = 0; i < text.len(); i++)
            pending_chars.push_back('{6'(text[i]), i == text.len() - 1});
    endfunction

    // Random value: full range, small magnitudes, powers of ten +-1, shortened words
    function automatic logic [VALUE_BITS-1:0] gen_value();
        logic [VALUE_BITS-1:0] v;
        longint                p;
        int                    sel;
        sel = $urandom_range(0, 99);
        if (sel < 35) begin
            v = $urandom;
        end else if (sel < 60) begin
            v = $urandom_range(0, 999);
        end else if (sel < 85) begin
            p = 1;
            repeat ($urandom_range(0, 9)) p = p * 10;
            v = VALUE_BITS'(p + longint'($urandom_range(0, 2)) - 1);
        end else begin
            v = $urandom >> $urandom_range(0, 31);
        end
        if (sel >= 35 && $urandom_range(0, 1) == 1)
            v = -v;
        return v;
    endfunction

    // Offer one item and hold it until accepted; valid stays high afterwards
    task automatic send_item(input logic [VALUE_BITS-1:0] value, input string text);
        s_tdata  <= TDATA_W'(value);
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        if (text.len() == 0)
            predict_decimal(value);
        else
            push_text(text);
    endtask

    // Between items: drain fully, take a gap at the end of a burst, or keep going
    task automatic pace(input bit drain_first);
        int gap;
        if (drain_first) begin
            s_tvalid <= 1'b0;
            while (pending_chars.size() != 0) @(posedge aclk);
        end else if (burst_left == 0) begin
            burst_left = $urandom_range(1, 10);
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 50) : $urandom_range(0, 3);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end else begin
            burst_left--;
        end
    endtask

    // Source: reset, directed table, random items, then end of run
    initial begin : source
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        foreach (vectors[i]) begin
            send_item(vectors[i].value, vectors[i].text);
            pace(1'b0);
        end
        for (int n = 0; n < RAND_ITEMS; n++) begin
            if (n == HOLD_AT)
                hold_request = 1'b1;
            send_item(gen_value(), "");
            pace(n + 1 == PAUSE_AT);
        end
        s_tvalid <= 1'b0;
        while (pending_chars.size() != 0) @(posedge aclk);
        repeat (DRAIN) @(posedge aclk);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Receiver: stall patterns over random spans, one long hold-off on request
    initial begin : sink
        rx_pattern_t pattern;
        int          span;
        int          phase;
        pattern = RX_OPEN;
        span    = 0;
        phase   = 0;
        wait (aresetn);
        forever begin
            @(posedge aclk);
            if (hold_request) begin
                hold_request = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            if (span == 0) begin
                pattern = rx_pattern_t'($urandom_range(0, 3));
                span    = $urandom_range(20, 120);
            end
            span--;
            phase++;
            case (pattern)
                RX_OPEN:        m_tready <= 1'b1;
                RX_COIN:        m_tready <= $urandom_range(0, 1);
                RX_ONE_IN_FOUR: m_tready <= (phase % 4 == 0);
                default:        m_tready <= ($urandom_range(0, 9) < 8);
            endcase
        end
    end

    // Compare each accepted character with the oldest expectation
    always @(posedge aclk) begin : check_chars
        char_exp_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_chars.size() == 0) begin
                report_mismatch($sformatf("character 0x%02h with nothing expected", m_tdata));
            end else begin
                want = pending_chars.pop_front();
                if (m_tdata !== {2'b00, want.code})
                    report_mismatch($sformatf("tdata 0x%02h, expected 0x%02h",
                                              m_tdata, {2'b00, want.code}));
                if (m_tlast !== want.last)
                    report_mismatch($sformatf("tlast %b, expected %b on 0x%02h",
                                              m_tlast, want.last, want.code));
            end
        end
    end

    // Watchdog on cycles with no item moving
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("status: fail");
                $finish;
            end
        end
    end

endmodule
